// ===== hw/rtl/hpa_pkg.sv =====
// ----------------------------------------------------------------------------
// hpa_pkg
// Shared codes and types of the handle pool allocator: operation codes,
// status codes and the command bundle from the controller to the datapath.
// ----------------------------------------------------------------------------
package hpa_pkg;

	// operation codes
	localparam logic [1:0] FUNC_ALLOC   = 2'd0;
	localparam logic [1:0] FUNC_RELEASE = 2'd1;
	localparam logic [1:0] FUNC_LOOKUP  = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_DEAD = 2'd2;

	// controller to datapath commands
	typedef struct packed {
		logic accept;
		logic commit;
	} hpa_cmd_t;

endpackage

// ===== hw/rtl/hpa_ram.sv =====
// ----------------------------------------------------------------------------
// hpa_ram
// Generic simple dual port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module hpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/hpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// hpa_ctrl
// Controller of the handle pool allocator: takes a transaction, runs the
// execute step and raises the result strobe.
// ----------------------------------------------------------------------------
module hpa_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	output logic             done,
	output hpa_pkg::hpa_cmd_t cmd
);

	import hpa_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   done_q;

	// state and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					done_q <= 1'b0;
					if (start) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
					done_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy       = (state_q == S_EXEC);
	assign done       = done_q;
	assign cmd.accept = start && !busy;
	assign cmd.commit = busy;

endmodule

// ===== hw/rtl/hpa_datapath.sv =====
// ----------------------------------------------------------------------------
// hpa_datapath
// Datapath of the handle pool allocator: free stack, in-use list and
// position map memories, live flags, counters and the result registers.
// ----------------------------------------------------------------------------
module hpa_datapath #(
	parameter int CAPACITY = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  hpa_pkg::hpa_cmd_t cmd,
	input  logic [1:0]        func,
	input  logic [7:0]        handle,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_wdata,
	output logic [1:0]        status,
	output logic [7:0]        granted_handle,
	output logic [23:0]       byte_offset,
	output logic [8:0]        live_count
);

	import hpa_pkg::*;

	localparam int HW     = $clog2(CAPACITY);
	localparam int CW     = $clog2(CAPACITY + 1);
	localparam int LIVE_N = (CAPACITY < 256) ? CAPACITY : 256;
	localparam int LW     = $clog2(LIVE_N);

	// control state
	logic [CW-1:0]     used_q;
	logic [CW-1:0]     hw_q;
	logic [LIVE_N-1:0] live_q;
	logic [15:0]       elem_q;

	// transaction captured at accept
	logic [1:0] op_s1;
	logic [7:0] handle_s1;
	logic       live_s1;

	// result registers
	logic [1:0]  status_q;
	logic [7:0]  granted_q;
	logic [23:0] offset_q;
	logic [8:0]  count_q;

	// memory ports
	logic          fs_we, iul_we, lp_we;
	logic [HW-1:0] fs_waddr, fs_wdata, fs_raddr, fs_rdata;
	logic [HW-1:0] iul_waddr, iul_wdata, iul_raddr, iul_rdata;
	logic [HW-1:0] lp_waddr, lp_wdata, lp_raddr, lp_rdata;

	logic          handle_live;
	logic          pool_full;
	logic          fresh;
	logic [HW-1:0] alloc_id;
	logic [HW-1:0] h_idx;
	logic          alloc_ok;
	logic          rel_ok;
	logic [CW-1:0] used_next;
	logic [23:0]   product;
	logic [1:0]    res_status;
	logic [7:0]    res_granted;
	logic [23:0]   res_offset;

	// live check at accept
	assign handle_live = (32'(handle) < CAPACITY) && live_q[LW'(handle)];

	// read addresses issued at accept
	assign fs_raddr  = HW'(CW'(CAPACITY - 1) - used_q);
	assign iul_raddr = HW'(used_q - CW'(1));
	assign lp_raddr  = HW'(handle);

	// stack top above the high-water mark reads as its reset value
	assign pool_full = (used_q == CW'(CAPACITY));
	assign fresh     = (used_q == hw_q);
	assign alloc_id  = fresh ? HW'(CW'(CAPACITY - 1) - used_q) : fs_rdata;
	assign h_idx     = HW'(handle_s1);

	assign alloc_ok = cmd.commit && (op_s1 == FUNC_ALLOC) && !pool_full;
	assign rel_ok   = cmd.commit && (op_s1 == FUNC_RELEASE) && live_s1;

	// list append on allocate, swap-remove on release
	assign iul_we    = alloc_ok || rel_ok;
	assign iul_waddr = alloc_ok ? HW'(used_q) : lp_rdata;
	assign iul_wdata = alloc_ok ? alloc_id : iul_rdata;
	assign lp_we     = alloc_ok || rel_ok;
	assign lp_waddr  = alloc_ok ? alloc_id : iul_rdata;
	assign lp_wdata  = alloc_ok ? HW'(used_q) : lp_rdata;

	// push released handle
	assign fs_we    = rel_ok;
	assign fs_waddr = HW'(CW'(CAPACITY) - used_q);
	assign fs_wdata = h_idx;

	always_comb begin
		used_next = used_q;
		if (alloc_ok) begin
			used_next = used_q + CW'(1);
		end else if (rel_ok) begin
			used_next = used_q - CW'(1);
		end
	end

	assign product = 24'(handle_s1) * 24'(elem_q);

	// result selection
	always_comb begin
		res_status  = ST_OK;
		res_granted = 8'd0;
		res_offset  = 24'd0;
		case (op_s1)
			FUNC_ALLOC: begin
				if (pool_full) begin
					res_status = ST_FULL;
				end else begin
					res_granted = 8'(alloc_id);
				end
			end
			FUNC_RELEASE: begin
				if (!live_s1) begin
					res_status = ST_DEAD;
				end
			end
			FUNC_LOOKUP: begin
				if (!live_s1) begin
					res_status = ST_DEAD;
				end else begin
					res_offset = product;
				end
			end
			default: begin
				res_status = ST_OK;
			end
		endcase
	end

	// counters, live flags and element size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			hw_q   <= '0;
			live_q <= '0;
			elem_q <= 16'd1;
		end else begin
			if (cfg_we) begin
				elem_q <= cfg_wdata;
			end
			if (cmd.commit) begin
				used_q <= used_next;
			end
			if (alloc_ok && fresh) begin
				hw_q <= hw_q + CW'(1);
			end
			if (alloc_ok && (32'(alloc_id) < LIVE_N)) begin
				live_q[LW'(alloc_id)] <= 1'b1;
			end
			if (rel_ok) begin
				live_q[LW'(h_idx)] <= 1'b0;
			end
		end
	end

	// transaction capture and result registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_s1     <= func;
			handle_s1 <= handle;
			live_s1   <= handle_live;
		end
		if (cmd.commit) begin
			status_q  <= res_status;
			granted_q <= res_granted;
			offset_q  <= res_offset;
			count_q   <= 9'(used_next);
		end
	end

	hpa_ram #(.WIDTH(HW), .DEPTH(CAPACITY)) u_free_stack (
		.clk   (clk),
		.we    (fs_we),
		.waddr (fs_waddr),
		.wdata (fs_wdata),
		.re    (cmd.accept),
		.raddr (fs_raddr),
		.rdata (fs_rdata)
	);

	hpa_ram #(.WIDTH(HW), .DEPTH(CAPACITY)) u_in_use_list (
		.clk   (clk),
		.we    (iul_we),
		.waddr (iul_waddr),
		.wdata (iul_wdata),
		.re    (cmd.accept),
		.raddr (iul_raddr),
		.rdata (iul_rdata)
	);

	hpa_ram #(.WIDTH(HW), .DEPTH(CAPACITY)) u_list_position (
		.clk   (clk),
		.we    (lp_we),
		.waddr (lp_waddr),
		.wdata (lp_wdata),
		.re    (cmd.accept),
		.raddr (lp_raddr),
		.rdata (lp_rdata)
	);

	assign status         = status_q;
	assign granted_handle = granted_q;
	assign byte_offset    = offset_q;
	assign live_count     = count_q;

endmodule

// ===== hw/rtl/handle_pool_allocator_top.sv =====
// ----------------------------------------------------------------------------
// handle_pool_allocator_top
// Fixed pool of CAPACITY handles with a free-handle stack, a dense in-use
// list and a position map; allocate, release and look up.
//
//   channel   | handshake        | payload
//   ----------+------------------+------------------------------------------
//   command   | start / busy     | func, handle
//   result    | done (strobe)    | status, granted_handle, byte_offset,
//             |                  | live_count
//   config    | cfg_we           | cfg_wdata (element size)
//
// A transaction is taken when start is high and busy is low. busy is high in
// the execute state, and the result strobe follows on the next cycle; a new
// transaction can be taken in the strobe cycle but not while busy. The
// execute state exists for the registered read of the stack, list and
// position memories, followed by their write-back.
// Reset needs no clearing pass: live flags clear at once and untouched stack
// entries read as their reset value through a high-water mark. The receiver
// cannot stall.
// ----------------------------------------------------------------------------
module handle_pool_allocator_top #(
	parameter int CAPACITY = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [7:0]  handle,
	output logic        done,
	output logic [1:0]  status,
	output logic [7:0]  granted_handle,
	output logic [23:0] byte_offset,
	output logic [8:0]  live_count,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	import hpa_pkg::*;

	hpa_cmd_t cmd;

	hpa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	hpa_datapath #(.CAPACITY(CAPACITY)) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.func           (func),
		.handle         (handle),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.status         (status),
		.granted_handle (granted_handle),
		.byte_offset    (byte_offset),
		.live_count     (live_count)
	);

	// execute state always goes straight back to idle
	a_exec_single: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held past one execute cycle");

	// every result strobe follows an accepted transaction through the execute state
	a_done_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result strobe without an accepted transaction");

	// pool full is reported only for an allocate
	a_full_on_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_FULL) |-> ($past(func, 2) == FUNC_ALLOC))
		else $error("pool full status for a non-allocate transaction");

	// failed operations give no handle and no offset
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (granted_handle == 8'd0 && byte_offset == 24'd0))
		else $error("failed transaction carries a handle or an offset");

endmodule

// ===== tb/sv/handle_pool_allocator_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// handle_pool_allocator_checker
// Passive checker for the handle pool allocator. It watches the command,
// result and element size channels and keeps its own copy of the free stack,
// in-use list and position map. It predicts the result of every accepted
// command and compares each strobed result, field by field, with the oldest
// prediction.
// ----------------------------------------------------------------------------
module handle_pool_allocator_checker #(
	parameter int CAPACITY = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  func,
	input  logic [7:0]  handle,
	input  logic        done,
	input  logic [1:0]  status,
	input  logic [7:0]  granted_handle,
	input  logic [23:0] byte_offset,
	input  logic [8:0]  live_count,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	output int          mismatch_count,
	output int          awaiting_count,
	output int          results_seen,
	output int          full_seen,
	output int          dead_seen,
	output int          peak_live
);

	import hpa_pkg::*;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  granted;
		logic [23:0] offset;
		logic [8:0]  live_total;
	} pool_result_t;

	// shadow of the pool
	int          free_ids [CAPACITY];
	int          free_total;
	int          live_order [CAPACITY];
	int          slot_of [CAPACITY];
	bit          is_live [CAPACITY];
	logic [15:0] elem_size;

	pool_result_t expected_q [$];

	task automatic reset_pool();
		for (int i = 0; i < CAPACITY; i++) begin
			free_ids[i] = i;
			live_order[i] = 0;
			slot_of[i] = 0;
			is_live[i] = 1'b0;
		end
		free_total = CAPACITY;
		elem_size = 16'd1;
		expected_q.delete();
		awaiting_count = 0;
	endtask

	// apply one command to the shadow pool and form its result
	task automatic predict_command(input logic [1:0] f, input logic [7:0] h,
		output pool_result_t r);
		int used;
		int id;
		int n;
		int moved;
		bit live_now;
		logic [31:0] prod;
		r = '0;
		used = CAPACITY - free_total;
		live_now = (int'(h) < CAPACITY) && is_live[h];
		case (f)
			FUNC_ALLOC: begin
				if (free_total == 0) begin
					r.status = ST_FULL;
				end else begin
					id = free_ids[free_total - 1];
					free_total--;
					live_order[used] = id;
					slot_of[id] = used;
					is_live[id] = 1'b1;
					r.granted = id[7:0];
				end
			end
			FUNC_RELEASE: begin
				if (!live_now) begin
					r.status = ST_DEAD;
				end else begin
					// swap-remove: the list tail fills the vacated slot
					n = slot_of[h];
					moved = live_order[used - 1];
					live_order[n] = moved;
					slot_of[moved] = n;
					live_order[used - 1] = 0;
					is_live[h] = 1'b0;
					free_ids[free_total] = int'(h);
					free_total++;
				end
			end
			FUNC_LOOKUP: begin
				if (!live_now) begin
					r.status = ST_DEAD;
				end else begin
					prod = 32'(h) * 32'(elem_size);
					r.offset = prod[23:0];
				end
			end
			default: ;
		endcase
		r.live_total = 9'(CAPACITY - free_total);
		if (r.status == ST_FULL) full_seen++;
		if (r.status == ST_DEAD) dead_seen++;
		if (CAPACITY - free_total > peak_live) peak_live = CAPACITY - free_total;
	endtask

	task automatic check_field(input string name, input logic [23:0] want,
		input logic [23:0] got);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= 40)
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	initial begin
		mismatch_count = 0;
		results_seen = 0;
		full_seen = 0;
		dead_seen = 0;
		peak_live = 0;
		reset_pool();
	end

	// config, result compare, then prediction of a new transaction
	always @(posedge clk or negedge arst_n) begin
		pool_result_t want;
		if (!arst_n) begin
			reset_pool();
		end else begin
			if (cfg_we) elem_size = cfg_wdata;
			if (done) begin
				results_seen++;
				if (expected_q.size() == 0) begin
					mismatch_count++;
					$display("%0t: result with no transaction waiting, status %0d", $time,
						status);
				end else begin
					want = expected_q.pop_front();
					check_field("status", 24'(want.status), 24'(status));
					check_field("granted_handle", 24'(want.granted), 24'(granted_handle));
					check_field("byte_offset", want.offset, byte_offset);
					check_field("live_count", 24'(want.live_total), 24'(live_count));
				end
			end
			if (start && !busy) begin
				predict_command(func, handle, want);
				expected_q.push_back(want);
			end
			awaiting_count = expected_q.size();
		end
	end

endmodule

// ===== tb/sv/handle_pool_allocator_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// handle_pool_allocator_top_tb
// Stimulus and verdict for the handle pool allocator. A short directed run
// walks the corner cases, then random phases fill the pool to overflow and
// drain it to empty again under different sender gaps and element sizes.
// The checker beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module handle_pool_allocator_top_tb;
	import hpa_pkg::*;

	localparam int CAPACITY    = 256;
	localparam int PHASE_ITEMS = 435;
	localparam int CYCLE_LIMIT = 200000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  func;
	logic [7:0]  handle;
	logic        done;
	logic [1:0]  status;
	logic [7:0]  granted_handle;
	logic [23:0] byte_offset;
	logic [8:0]  live_count;
	logic        cfg_we;
	logic [15:0] cfg_wdata;

	int mismatch_count;
	int awaiting_count;
	int results_seen;
	int full_seen;
	int dead_seen;
	int peak_live;

	int idle_pct;
	int cycle_count;

	// operations in flight, and handles the stimulus believes are granted
	logic [1:0] ops_in_flight [$];
	logic [7:0] held [$];

	handle_pool_allocator_top #(
		.CAPACITY(CAPACITY)
	) DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.func           (func),
		.handle         (handle),
		.done           (done),
		.status         (status),
		.granted_handle (granted_handle),
		.byte_offset    (byte_offset),
		.live_count     (live_count),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata)
	);

	handle_pool_allocator_checker #(
		.CAPACITY(CAPACITY)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.func           (func),
		.handle         (handle),
		.done           (done),
		.status         (status),
		.granted_handle (granted_handle),
		.byte_offset    (byte_offset),
		.live_count     (live_count),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.mismatch_count (mismatch_count),
		.awaiting_count (awaiting_count),
		.results_seen   (results_seen),
		.full_seen      (full_seen),
		.dead_seen      (dead_seen),
		.peak_live      (peak_live)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// timeout
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
			awaiting_count);
		$display("Test completed with failures");
		$finish;
	end

	// track granted handles from the result strobe
	always @(posedge clk) begin
		logic [1:0] op;
		if (done && ops_in_flight.size() > 0) begin
			op = ops_in_flight.pop_front();
			if (op == FUNC_ALLOC && status == ST_OK) held.push_back(granted_handle);
		end
	end

	// one command transaction, with a random sender gap ahead of it
	task automatic issue(input logic [1:0] f, input logic [7:0] h);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			func <= 2'($urandom_range(3));
			handle <= 8'($urandom_range(255));
			@(posedge clk);
		end
		start <= 1'b1;
		func <= f;
		handle <= h;
		@(posedge clk);
		while (busy) @(posedge clk);
		ops_in_flight.push_back(f);
	endtask

	// stop sending and wait until every result has come back
	task automatic settle();
		start <= 1'b0;
		do @(negedge clk); while (awaiting_count != 0);
		@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	initial begin
		bit filling;
		int full_tries;
		int r;
		int idx;
		int alloc_pct;
		int release_pct;
		logic [1:0] f;
		logic [7:0] h;

		arst_n = 1'b0;
		start = 1'b0;
		func = FUNC_ALLOC;
		handle = 8'd0;
		cfg_we = 1'b0;
		cfg_wdata = 16'd0;
		idle_pct = 0;
		filling = 1'b1;
		full_tries = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed corner cases at the reset element size
		issue(FUNC_LOOKUP, 8'd0);       // lookup on an empty pool
		issue(FUNC_RELEASE, 8'd255);    // release of a dead handle
		issue(2'd3, 8'hAA);             // unused operation
		issue(FUNC_ALLOC, 8'h55);       // handle field ignored, gets 255
		issue(FUNC_LOOKUP, 8'd255);
		issue(FUNC_ALLOC, 8'd0);
		issue(FUNC_ALLOC, 8'hFF);
		issue(FUNC_RELEASE, 8'd254);    // middle of the list, tail moves in
		issue(FUNC_LOOKUP, 8'd254);     // now dead
		issue(FUNC_RELEASE, 8'd254);    // double release
		issue(FUNC_LOOKUP, 8'd253);
		issue(FUNC_ALLOC, 8'd0);        // freshly pushed handle comes back
		issue(FUNC_RELEASE, 8'd255);    // head of the list
		issue(FUNC_RELEASE, 8'd253);
		issue(FUNC_RELEASE, 8'd254);    // pool empty again
		issue(FUNC_RELEASE, 8'd0);
		issue(2'd3, 8'd0);
		settle();
		held.delete();

		// random phases: element size and sender gaps vary per phase;
		// the result side cannot stall, so the first and third phases run without gaps
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: cfg_wdata <= 16'hFFFF;
				1: cfg_wdata <= 16'h0000;
				2: cfg_wdata <= 16'($urandom_range(65534, 2));
				default: cfg_wdata <= 16'd1;
			endcase
			cfg_we <= 1'b1;
			@(posedge clk);
			cfg_we <= 1'b0;
			case (p)
				1: idle_pct = 77;
				3: idle_pct = 26;
				default: idle_pct = 0;
			endcase

			repeat (PHASE_ITEMS) begin
				// fill to overflow, then drain to empty
				alloc_pct = filling ? 55 : 15;
				release_pct = filling ? 15 : 55;
				r = $urandom_range(99);
				if (r < alloc_pct) begin
					issue(FUNC_ALLOC, 8'($urandom_range(255)));
				end else if (r < alloc_pct + release_pct && held.size() > 0) begin
					idx = $urandom_range(held.size() - 1);
					h = held[idx];
					held.delete(idx);
					issue(FUNC_RELEASE, h);
				end else if (r < alloc_pct + release_pct + 15 && held.size() > 0) begin
					issue(FUNC_LOOKUP, held[$urandom_range(held.size() - 1)]);
				end else begin
					// noise: any operation on any handle
					f = 2'($urandom_range(3));
					h = 8'($urandom_range(255));
					if (f == FUNC_RELEASE) begin
						for (int i = held.size() - 1; i >= 0; i--)
							if (held[i] == h) held.delete(i);
					end
					issue(f, h);
				end

				if (filling && held.size() >= CAPACITY) full_tries++;
				if (full_tries >= 8) begin
					filling = 1'b0;
					full_tries = 0;
				end
				if (!filling && held.size() == 0) filling = 1'b1;
			end
			settle();
		end

		$display("%0d transactions checked, element sizes 1, 65535, 0 and one random",
			results_seen);
		$display("%0d pool-full allocates, %0d dead-handle requests, peak %0d live",
			full_seen, dead_seen, peak_live);
		if (mismatch_count == 0 && awaiting_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
